### src/ftma_pkg.sv
// Shared types and constants for the force/torque datagram moving-average block.
package ftma_pkg;

    localparam int DATAGRAM_BYTES = 36;
    localparam int NUM_CH         = 6;
    localparam int NUM_HDR        = 3;
    localparam int WORD_W         = 32;
    localparam int POS_W          = 6;

    localparam logic [POS_W-1:0] POS_MAX  = 6'd63;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DATAGRAM_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END  = POS_W'(DATAGRAM_BYTES);
    localparam logic [3:0]       HDR_WORDS = 4'(NUM_HDR);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam int TDATA_W      = (NUM_CH + NUM_HDR) * WORD_W;
    localparam int TUSER_W      = 2;
    localparam int TUSER_FULL   = 0;
    localparam int TUSER_LENERR = 1;

    // One received datagram as handed from the byte front end to the averaging back end.
    typedef struct packed {
        logic                              good;
        logic [NUM_HDR-1:0][WORD_W-1:0]    hdr;
        logic [NUM_CH-1:0][WORD_W-1:0]     counts;
    } dgram_t;

endpackage

### src/ftma_front.sv
// Byte assembly front end: builds words, checks datagram length, emits one request per datagram.
module ftma_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 push_valid,
    input  logic                 push_ready,
    output ftma_pkg::dgram_t     push_data
);

    logic [ftma_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [ftma_pkg::WORD_W-1:0] word_reg, word_next;
    logic [ftma_pkg::NUM_HDR-1:0][ftma_pkg::WORD_W-1:0] hdr_reg, hdr_next;
    logic [ftma_pkg::NUM_CH-1:0][ftma_pkg::WORD_W-1:0] cnt_reg, cnt_next;
    logic [3:0] word_idx;
    logic [3:0] cnt_idx;
    logic       accept;

    assign accept   = in_valid && push_ready;
    assign word_idx = pos_reg[5:2];
    assign cnt_idx  = word_idx - ftma_pkg::HDR_WORDS;

    always_comb begin
        word_next = {word_reg[23:0], in_byte};
        hdr_next  = hdr_reg;
        cnt_next  = cnt_reg;
        // Every fourth byte inside the datagram completes a word.
        if (pos_reg < ftma_pkg::POS_END && pos_reg[1:0] == 2'b11) begin
            if (word_idx < ftma_pkg::HDR_WORDS) begin
                hdr_next[word_idx[1:0]] = word_next;
            end else begin
                cnt_next[cnt_idx[2:0]] = word_next;
            end
        end
        if (in_last) begin
            pos_next = '0;
        end else if (pos_reg == ftma_pkg::POS_MAX) begin
            pos_next = pos_reg;
        end else begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= word_next;
            hdr_reg  <= hdr_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign push_valid       = in_valid && in_last;
    assign push_data.good   = (pos_reg == ftma_pkg::POS_LAST);
    assign push_data.hdr    = hdr_next;
    assign push_data.counts = cnt_next;

endmodule

### src/ftma_queue.sv
// Short request queue between the byte front end and the averaging back end.
module ftma_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  ftma_pkg::dgram_t     wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output ftma_pkg::dgram_t     rd_data
);

    ftma_pkg::dgram_t slot_reg [ftma_pkg::QUEUE_DEPTH];
    logic [ftma_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ftma_pkg::QUEUE_AW:0]   count_reg;
    logic do_wr, do_rd;

    assign wr_ready = (count_reg != (ftma_pkg::QUEUE_AW+1)'(ftma_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/ftma_back.sv
// Averaging back end: history ring, running sums, floor division by the window and result register.
module ftma_back #(
    parameter int WINDOW = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  ftma_pkg::dgram_t              q_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ftma_pkg::TDATA_W-1:0]  out_data,
    output logic [ftma_pkg::TUSER_W-1:0]  out_user
);

    localparam int LOG_W = $clog2(WINDOW);
    localparam int SUM_W = ftma_pkg::WORD_W + LOG_W;
    localparam bit POW2  = ((WINDOW & (WINDOW - 1)) == 0);
    localparam logic [LOG_W-1:0] LAST_SLOT = LOG_W'(WINDOW - 1);
    // Offset that makes every possible sum non-negative; the quotient then carries 2^31 extra.
    localparam logic [SUM_W:0]   BIAS      = (SUM_W+1)'(WINDOW) << 31;

    // The biased sum is divided one byte per cycle, most significant byte first.
    localparam int NUM_DIG  = (SUM_W + 8) / 8;
    localparam int DIV_W    = NUM_DIG * 8;
    localparam int PART_W   = LOG_W + 8;
    localparam int RECIP_SH = PART_W + LOG_W;
    localparam int PROD_W   = PART_W + RECIP_SH + 1;
    localparam logic [RECIP_SH:0] RECIP =
        (RECIP_SH+1)'(((1 << RECIP_SH) + WINDOW - 1) / WINDOW);
    localparam logic [PART_W-1:0] DIV_K = PART_W'(WINDOW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;
    localparam logic [2:0] DIV_LAST = 3'(NUM_DIG - 1);

    logic [1:0]       state_reg, state_next;
    logic [LOG_W-1:0] ptr_reg, ptr_next, ptr_adv;
    logic [LOG_W-1:0] fill_reg, fill_next;
    logic             full_reg, full_next;
    logic [2:0]       div_cnt_reg, div_cnt_next;

    logic signed [SUM_W-1:0] sum_reg  [ftma_pkg::NUM_CH];
    logic signed [SUM_W-1:0] sum_next [ftma_pkg::NUM_CH];
    logic [ftma_pkg::NUM_CH-1:0][ftma_pkg::WORD_W-1:0]  avg_reg, avg_next;
    logic [ftma_pkg::NUM_HDR-1:0][ftma_pkg::WORD_W-1:0] hdr_reg, hdr_next;

    logic [LOG_W-1:0]  rem_reg  [ftma_pkg::NUM_CH];
    logic [LOG_W-1:0]  rem_next [ftma_pkg::NUM_CH];
    logic [DIV_W-1:0]  num_reg  [ftma_pkg::NUM_CH];
    logic [DIV_W-1:0]  num_next [ftma_pkg::NUM_CH];
    logic [PART_W-1:0] part     [ftma_pkg::NUM_CH];
    logic [PROD_W-1:0] prod     [ftma_pkg::NUM_CH];
    logic [7:0]        digit    [ftma_pkg::NUM_CH];
    logic [PART_W-1:0] part_rem [ftma_pkg::NUM_CH];
    logic [SUM_W:0]    biased   [ftma_pkg::NUM_CH];

    logic [ftma_pkg::NUM_CH-1:0][ftma_pkg::WORD_W-1:0] ring_mem [WINDOW];
    logic [ftma_pkg::NUM_CH-1:0][ftma_pkg::WORD_W-1:0] old_reg;
    logic ring_we;

    logic                         out_valid_reg, out_valid_next;
    logic [ftma_pkg::TDATA_W-1:0] out_data_reg, out_data_next;
    logic [ftma_pkg::TUSER_W-1:0] out_user_reg, out_user_next;
    logic                         out_free;

    assign ptr_adv  = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    assign out_free = !out_valid_reg || out_ready;

    // One quotient byte per channel from a reciprocal multiply, and the biased sum that
    // seeds the divider.
    always_comb begin
        for (int ch = 0; ch < ftma_pkg::NUM_CH; ch++) begin
            part[ch]     = {rem_reg[ch], num_reg[ch][DIV_W-1 -: 8]};
            prod[ch]     = PROD_W'(part[ch]) * PROD_W'(RECIP);
            digit[ch]    = prod[ch][RECIP_SH +: 8];
            part_rem[ch] = part[ch] - PART_W'(digit[ch]) * DIV_K;
            biased[ch]   = {sum_reg[ch][SUM_W-1], sum_reg[ch]} + BIAS;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        full_next      = full_reg;
        div_cnt_next   = div_cnt_reg;
        avg_next       = avg_reg;
        hdr_next       = hdr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        q_ready        = 1'b0;
        ring_we        = 1'b0;
        for (int ch = 0; ch < ftma_pkg::NUM_CH; ch++) begin
            sum_next[ch] = sum_reg[ch];
            rem_next[ch] = rem_reg[ch];
            num_next[ch] = num_reg[ch];
        end
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (!q_data.good) begin
                        // A dropped datagram reports the held averages with a cleared header.
                        if (out_free) begin
                            q_ready        = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = {{(ftma_pkg::NUM_HDR*ftma_pkg::WORD_W){1'b0}},
                                              avg_reg};
                            out_user_next  = {1'b1, full_reg};
                        end
                    end else begin
                        q_ready  = 1'b1;
                        ring_we  = 1'b1;
                        hdr_next = q_data.hdr;
                        ptr_next = ptr_adv;
                        for (int ch = 0; ch < ftma_pkg::NUM_CH; ch++) begin
                            sum_next[ch] = sum_reg[ch] +
                                {{LOG_W{q_data.counts[ch][ftma_pkg::WORD_W-1]}},
                                 q_data.counts[ch]};
                        end
                        if (fill_reg != LAST_SLOT) begin
                            fill_next  = fill_reg + 1'b1;
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD: begin
                // The oldest sample leaves the sum after the average is taken from it.
                full_next = 1'b1;
                for (int ch = 0; ch < ftma_pkg::NUM_CH; ch++) begin
                    sum_next[ch] = sum_reg[ch] -
                        {{LOG_W{old_reg[ch][ftma_pkg::WORD_W-1]}}, old_reg[ch]};
                    rem_next[ch] = '0;
                    num_next[ch] = DIV_W'(biased[ch]);
                    if (POW2) begin
                        avg_next[ch] = sum_reg[ch][SUM_W-1:LOG_W];
                    end
                end
                div_cnt_next = '0;
                state_next   = POW2 ? ST_EMIT : ST_DIV;
            end
            ST_DIV: begin
                div_cnt_next = div_cnt_reg + 1'b1;
                for (int ch = 0; ch < ftma_pkg::NUM_CH; ch++) begin
                    rem_next[ch] = part_rem[ch][LOG_W-1:0];
                    num_next[ch] = {num_reg[ch][DIV_W-9:0], digit[ch]};
                    if (div_cnt_reg == DIV_LAST) begin
                        avg_next[ch] = {~num_reg[ch][ftma_pkg::WORD_W-9],
                                        num_reg[ch][ftma_pkg::WORD_W-10:0], digit[ch]};
                    end
                end
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {hdr_reg, avg_reg};
                    out_user_next  = {1'b0, full_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            full_reg      <= 1'b0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int ch = 0; ch < ftma_pkg::NUM_CH; ch++) begin
                sum_reg[ch] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            full_reg      <= full_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
            for (int ch = 0; ch < ftma_pkg::NUM_CH; ch++) begin
                sum_reg[ch] <= sum_next[ch];
            end
        end
    end

    always_ff @(posedge aclk) begin
        div_cnt_reg  <= div_cnt_next;
        hdr_reg      <= hdr_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        for (int ch = 0; ch < ftma_pkg::NUM_CH; ch++) begin
            rem_reg[ch] <= rem_next[ch];
            num_reg[ch] <= num_next[ch];
        end
    end

    // History ring: the new sample goes to the current slot, the oldest is read from the next.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ptr_reg] <= q_data.counts;
            old_reg           <= ring_mem[ptr_adv];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

### src/ft_packet_moving_average_core.sv
// Top level of the six-channel force/torque datagram moving-average block.
//
// The input stream carries one datagram byte per request on s_tdata, with s_tlast on the
// final byte. A datagram of exactly 36 bytes updates a WINDOW-deep boxcar average of the
// six signed counts; any other length is dropped and reported with length_error set.
// Every byte marked by s_tlast yields one result request on the m_ side: the six averages,
// the three header words (zero for a dropped datagram) and the window_full and
// length_error flags. Averages read zero until WINDOW good datagrams have arrived.
// Bytes are taken one per cycle while s_tready is high. A dropped datagram's result is
// registered straight from IDLE, a good one's via EMIT while the window fills, and once
// full via LOAD and EMIT (power-of-two WINDOW) or LOAD, DIV and EMIT (other WINDOW, one
// quotient byte per cycle from a reciprocal multiply in each channel). A four-entry
// datagram queue decouples the byte side from the averaging side; s_tready drops only
// when it is full, which happens when m_tready stays low or short datagrams arrive faster
// than the averaging completes. Reset clears the sums, averages, ring pointer and queue.
module ft_packet_moving_average_core #(
    parameter int WINDOW = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // rx_byte
    input  logic                          s_tlast,   // end_of_datagram
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // avg_fx, avg_fy, avg_fz, avg_tx, avg_ty, avg_tz, rdt_seq, ft_seq, sensor_status
    output logic [ftma_pkg::TDATA_W-1:0]  m_tdata,
    output logic [ftma_pkg::TUSER_W-1:0]  m_tuser    // window_full, length_error
);

    logic             push_valid, push_ready;
    ftma_pkg::dgram_t push_data;
    logic             q_valid, q_ready;
    ftma_pkg::dgram_t q_data;

    assign s_tready = push_ready;

    ftma_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ftma_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    ftma_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

### src/ftma_checker.sv
// Port-level checker for the moving-average block, bound to its top level.
module ftma_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ftma_pkg::TDATA_W-1:0]  m_tdata,
    input logic [ftma_pkg::TUSER_W-1:0]  m_tuser
);

    localparam int AVG_W = ftma_pkg::NUM_CH * ftma_pkg::WORD_W;

    logic seen_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_full_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tuser[ftma_pkg::TUSER_FULL]) begin
            seen_full_reg <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_drop_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[ftma_pkg::TUSER_LENERR] |-> m_tdata[ftma_pkg::TDATA_W-1:AVG_W] == '0)
        else $error("dropped datagram reports a header");

    a_zero_until_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[ftma_pkg::TUSER_FULL] |-> m_tdata[AVG_W-1:0] == '0)
        else $error("average reported before the window filled");

    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_full_reg |-> m_tuser[ftma_pkg::TUSER_FULL])
        else $error("window_full fell after being reported");

endmodule

bind ft_packet_moving_average_core ftma_checker u_ftma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### sim/ft_packet_moving_average_core_tb.sv
// Self-checking testbench for the force/torque datagram moving-average block.
`timescale 1ns / 1ps

module ft_packet_moving_average_core_tb;

    localparam int WINDOW       = 8;
    localparam int NUM_CH       = ftma_pkg::NUM_CH;
    localparam int NUM_HDR      = ftma_pkg::NUM_HDR;
    localparam int WORD_W       = ftma_pkg::WORD_W;
    localparam int NUM_WORDS    = NUM_HDR + NUM_CH;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int CALM_START   = 300;
    localparam int CALM_END     = 600;
    localparam int RAND_BYTES   = 325;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_byte_t;

    typedef struct packed {
        logic [NUM_CH-1:0][WORD_W-1:0]  avg;
        logic [NUM_HDR-1:0][WORD_W-1:0] hdr;
        logic                           full;
        logic                           len_err;
    } ft_result_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = 8'd0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ftma_pkg::TDATA_W-1:0]  m_tdata;
    logic [ftma_pkg::TUSER_W-1:0]  m_tuser;

    rx_byte_t   byte_queue[$];
    ft_result_t pending_averages[$];
    int         errors      = 0;
    int         cycle_count = 0;

    // Shadow state of the byte assembler and the averaging back end.
    logic [ftma_pkg::POS_W-1:0] rx_pos = '0;
    logic [WORD_W-1:0] rx_word = '0;
    logic [WORD_W-1:0] rx_hdr[NUM_HDR];
    logic [WORD_W-1:0] rx_counts[NUM_CH];
    longint            ring[NUM_CH][WINDOW];
    int                ring_slot = 0;
    int                fill = 0;
    longint            ch_sum[NUM_CH];
    logic [WORD_W-1:0] ch_avg[NUM_CH];
    bit                win_full = 1'b0;

    ft_packet_moving_average_core #(
        .WINDOW(WINDOW)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    function automatic bit idle_roll();
        if (cycle_count >= CALM_START && cycle_count < CALM_END)
            return 1'b0;
        return $urandom_range(0, 99) < 29;
    endfunction

    // Folds the current datagram into the ring and sums; averages start once the window is full.
    task automatic absorb_datagram();
        longint v;
        longint q;
        int     nxt;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            v = longint'(signed'(rx_counts[ch]));
            ring[ch][ring_slot] = v;
            ch_sum[ch] += v;
        end
        nxt = (ring_slot + 1) % WINDOW;
        ring_slot = nxt;
        if (fill < WINDOW - 1) begin
            fill++;
        end else begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                q = ch_sum[ch] / WINDOW;
                if ((ch_sum[ch] % WINDOW) != 0 && ch_sum[ch] < 0)
                    q = q - 1;
                ch_avg[ch] = q[WORD_W-1:0];
                ch_sum[ch] -= ring[ch][nxt];
            end
            win_full = 1'b1;
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        int         idx;
        bit         good;
        ft_result_t r;
        rx_word = {rx_word[23:0], b};
        if (rx_pos < ftma_pkg::POS_END && rx_pos[1:0] == 2'b11) begin
            idx = int'(rx_pos >> 2);
            if (idx < NUM_HDR)
                rx_hdr[idx] = rx_word;
            else
                rx_counts[idx - NUM_HDR] = rx_word;
        end
        if (!last) begin
            if (rx_pos < ftma_pkg::POS_MAX)
                rx_pos = rx_pos + 1'b1;
        end else begin
            good = (rx_pos == ftma_pkg::POS_LAST);
            rx_pos = '0;
            rx_word = '0;
            if (good)
                absorb_datagram();
            for (int ch = 0; ch < NUM_CH; ch++)
                r.avg[ch] = ch_avg[ch];
            for (int h = 0; h < NUM_HDR; h++)
                r.hdr[h] = good ? rx_hdr[h] : '0;
            r.full = win_full;
            r.len_err = !good;
            pending_averages = {pending_averages, r};
        end
    endtask

    // Bytes 0..35 are the big-endian image of the nine words; any beyond that are random.
    task automatic queue_datagram(input int len, input logic [NUM_WORDS-1:0][WORD_W-1:0] words);
        rx_byte_t item;
        for (int k = 0; k < len; k++) begin
            if (k < ftma_pkg::DATAGRAM_BYTES)
                item.data = words[k / 4][31 - 8 * (k % 4) -: 8];
            else
                item.data = 8'($urandom());
            item.last = (k == len - 1);
            byte_queue = {byte_queue, item};
        end
    endtask

    function automatic logic [WORD_W-1:0] random_count();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 2000)) - 32'd1000;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (byte_queue.size() > 0 && !idle_roll()) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_queue[0].data;
                    s_tlast  <= byte_queue[0].last;
                    void'(byte_queue.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_result();
        ft_result_t exp_r;
        if (pending_averages.size() == 0) begin
            $display("%0t: result request with none expected, tdata %h tuser %b",
                     $time, m_tdata, m_tuser);
            errors++;
        end else begin
            exp_r = pending_averages.pop_front();
            for (int ch = 0; ch < NUM_CH; ch++)
                if (m_tdata[ch*WORD_W +: WORD_W] !== exp_r.avg[ch]) begin
                    $display("%0t: average ch%0d expected %h, got %h", $time, ch,
                             exp_r.avg[ch], m_tdata[ch*WORD_W +: WORD_W]);
                    errors++;
                end
            for (int h = 0; h < NUM_HDR; h++)
                if (m_tdata[(NUM_CH + h)*WORD_W +: WORD_W] !== exp_r.hdr[h]) begin
                    $display("%0t: header word %0d expected %h, got %h", $time, h,
                             exp_r.hdr[h], m_tdata[(NUM_CH + h)*WORD_W +: WORD_W]);
                    errors++;
                end
            if (m_tuser[ftma_pkg::TUSER_FULL] !== exp_r.full) begin
                $display("%0t: window_full expected %b, got %b", $time,
                         exp_r.full, m_tuser[ftma_pkg::TUSER_FULL]);
                errors++;
            end
            if (m_tuser[ftma_pkg::TUSER_LENERR] !== exp_r.len_err) begin
                $display("%0t: length_error expected %b, got %b", $time,
                         exp_r.len_err, m_tuser[ftma_pkg::TUSER_LENERR]);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            m_tready <= !idle_roll();
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("ft_packet_moving_average_core verification failed");
        $finish;
    end

    initial begin
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
        int rand_bytes;
        int len;

        for (int ch = 0; ch < NUM_CH; ch++) begin
            ch_sum[ch] = 0;
            ch_avg[ch] = '0;
            rx_counts[ch] = '0;
            for (int s = 0; s < WINDOW; s++)
                ring[ch][s] = 0;
        end
        for (int h = 0; h < NUM_HDR; h++)
            rx_hdr[h] = '0;

        // An end mark on the very first byte, before any good datagram.
        words = '0;
        queue_datagram(1, words);
        // A full window of extreme counts, alternating between the two signed limits.
        for (int k = 0; k < WINDOW; k++) begin
            for (int h = 0; h < NUM_HDR; h++)
                words[h] = k[0] ? 32'h0000_0000 : 32'hFFFF_FFFF;
            for (int ch = 0; ch < NUM_CH; ch++)
                words[NUM_HDR + ch] = ((k + ch) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            queue_datagram(ftma_pkg::DATAGRAM_BYTES, words);
        end
        // One byte short, one byte long, and one long enough to saturate the byte count.
        queue_datagram(ftma_pkg::DATAGRAM_BYTES - 1, words);
        queue_datagram(ftma_pkg::DATAGRAM_BYTES + 1, words);
        queue_datagram(70, words);
        // Small negative sums exercise rounding toward minus infinity.
        for (int k = 0; k < 3; k++) begin
            for (int w = 0; w < NUM_WORDS; w++)
                words[w] = (w < NUM_HDR) ? $urandom() : 32'hFFFF_FFFF;
            queue_datagram(ftma_pkg::DATAGRAM_BYTES, words);
        end
        words = '0;
        queue_datagram(ftma_pkg::DATAGRAM_BYTES, words);

        rand_bytes = 0;
        while (rand_bytes < RAND_BYTES) begin
            for (int h = 0; h < NUM_HDR; h++)
                words[h] = $urandom();
            for (int ch = 0; ch < NUM_CH; ch++)
                words[NUM_HDR + ch] = random_count();
            if ($urandom_range(0, 99) < 80) begin
                len = ftma_pkg::DATAGRAM_BYTES;
            end else begin
                case ($urandom_range(0, 3))
                    0: len = ftma_pkg::DATAGRAM_BYTES - 1;
                    1: len = ftma_pkg::DATAGRAM_BYTES + 1;
                    2: len = $urandom_range(1, ftma_pkg::DATAGRAM_BYTES - 1);
                    default: len = $urandom_range(ftma_pkg::DATAGRAM_BYTES + 1, 80);
                endcase
            end
            queue_datagram(len, words);
            rand_bytes += len;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_queue.size() > 0 || s_tvalid || pending_averages.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && pending_averages.size() == 0) begin
            $display("ft_packet_moving_average_core verification clean");
        end else begin
            $display("ft_packet_moving_average_core verification failed");
        end
        $finish;
    end

endmodule

### files.f
src/ftma_pkg.sv
src/ftma_front.sv
src/ftma_queue.sv
src/ftma_back.sv
src/ft_packet_moving_average_core.sv
src/ftma_checker.sv
sim/ft_packet_moving_average_core_tb.sv
